/* rtl/tfwm_pkg.sv */
// Shared types and character constants for the topic filter wildcard matcher.
// No dependencies; every other file of the block imports this package.
package tfwm_pkg;

   localparam logic [7:0] CH_HASH  = 8'h23;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // Match progress of the topic in flight.
   typedef enum logic [3:0] {
      ST_RUNNING  = 4'b0001,
      ST_SKIPPING = 4'b0010,
      ST_HASH     = 4'b0100,
      ST_FAILED   = 4'b1000
   } status_type;

   typedef struct packed {
      logic       is_topic;
      logic [7:0] char_byte;
      logic       last_char;
   } item_type;

   typedef struct packed {
      logic matched;
      logic filter_ok;
      logic topic_ok;
   } result_type;

endpackage

/* rtl/tfwm_filter_store.sv */
// Filter byte memory: one write port and two registered read ports.
// Reads the bytes at the match position and the one after it; uses tfwm_pkg.
module tfwm_filter_store #(
   parameter int MAX_TOPIC_LEN = 128,
   localparam int AW = $clog2(MAX_TOPIC_LEN),
   localparam int LW = $clog2(MAX_TOPIC_LEN + 1)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [LW-1:0] rd_pos,
   output logic [7:0]    rd_data0,
   output logic [7:0]    rd_data1
);
   import tfwm_pkg::*;

   logic [7:0]  store_ff [MAX_TOPIC_LEN];
   logic [7:0]  rd0_ff;
   logic [7:0]  rd1_ff;
   logic [LW:0] rd_next;
   logic        rd0_ok;
   logic        rd1_ok;
   logic [AW-1:0] rd0_addr;
   logic [AW-1:0] rd1_addr;

   assign rd_next  = {1'b0, rd_pos} + 1'b1;
   assign rd0_ok   = rd_pos < LW'(MAX_TOPIC_LEN);
   assign rd1_ok   = rd_next < (LW+1)'(MAX_TOPIC_LEN);
   assign rd0_addr = rd_pos[AW-1:0];
   assign rd1_addr = rd_next[AW-1:0];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // A byte written in the same cycle is forwarded so the read data always
   // reflects the filter as it stands for the next request.
   always_ff @(posedge clock) begin
      if (rd0_ok) begin
         rd0_ff <= (wr_en && wr_addr == rd0_addr) ? wr_data : store_ff[rd0_addr];
      end
      if (rd1_ok) begin
         rd1_ff <= (wr_en && wr_addr == rd1_addr) ? wr_data : store_ff[rd1_addr];
      end
   end

   assign rd_data0 = rd0_ff;
   assign rd_data1 = rd1_ff;

endmodule

/* rtl/tfwm_match_core.sv */
// Filter load checks, topic checks and the streaming wildcard matcher.
// Holds all matcher state; drives the filter store in tfwm_filter_store; uses tfwm_pkg.
module tfwm_match_core #(
   parameter int MAX_TOPIC_LEN = 128,
   localparam int AW = $clog2(MAX_TOPIC_LEN),
   localparam int LW = $clog2(MAX_TOPIC_LEN + 1)
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  tfwm_pkg::item_type   item,
   input  logic [7:0]           rd_data0,
   input  logic [7:0]           rd_data1,
   output logic                 wr_en,
   output logic [AW-1:0]        wr_addr,
   output logic [7:0]           wr_data,
   output logic [LW-1:0]        rd_pos,
   output tfwm_pkg::result_type result
);
   import tfwm_pkg::*;

   logic [LW-1:0] flen_ff, flen_in;
   logic          fover_ff, fover_in;
   logic          fvalid_ff, fvalid_in;
   logic [7:0]    fprev_ff, fprev_in;
   logic          plus_slash_ff, plus_slash_in;
   logic          fstart_ff, fstart_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [LW-1:0] tlen_ff, tlen_in;
   logic          tvalid_ff, tvalid_in;
   status_type    status_ff, status_in;
   logic          tstart_ff, tstart_in;

   always_comb begin
      logic [LW-1:0] fl;
      logic          fo;
      logic          fv;
      logic [7:0]    fp;
      logic          ps;
      logic          first;
      logic [7:0]    c;
      logic [LW-1:0] p;
      logic [LW-1:0] p_n;
      logic [LW:0]   p1;
      logic [LW:0]   pn1;
      logic          tv;
      logic [LW-1:0] tl;
      status_type    st_n;
      logic          m;
      logic          fok;

      flen_in       = flen_ff;
      fover_in      = fover_ff;
      fvalid_in     = fvalid_ff;
      fprev_in      = fprev_ff;
      plus_slash_in = plus_slash_ff;
      fstart_in     = fstart_ff;
      pos_in        = pos_ff;
      tlen_in       = tlen_ff;
      tvalid_in     = tvalid_ff;
      status_in     = status_ff;
      tstart_in     = tstart_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = item.char_byte;
      result        = '0;

      c  = item.char_byte;
      fl = fstart_ff ? '0 : flen_ff;
      fo = fstart_ff ? 1'b0 : fover_ff;
      fv = fstart_ff ? 1'b1 : fvalid_ff;
      fp = fstart_ff ? 8'h00 : fprev_ff;
      ps = fstart_ff ? 1'b0 : plus_slash_ff;
      first = (fl == '0) && !fo;

      // Topic registers are returned to their start values when a topic ends,
      // so the position register always holds the live match position.
      p    = pos_ff;
      p_n  = pos_ff;
      p1   = {1'b0, pos_ff} + 1'b1;
      pn1  = '0;
      st_n = status_ff;
      tv   = tvalid_ff;
      tl   = tlen_ff;
      m    = 1'b0;
      fok  = fvalid_ff && fstart_ff;

      if (step && !item.is_topic) begin
         if (c == CH_NUL) fv = 1'b0;
         if (!first && fp == CH_HASH) fv = 1'b0;
         if (ps && c != CH_SLASH) fv = 1'b0;
         if ((c == CH_HASH || c == CH_PLUS) && !first && fp != CH_SLASH) fv = 1'b0;
         plus_slash_in = (c == CH_PLUS);
         fprev_in      = c;
         if (fl < LW'(MAX_TOPIC_LEN)) begin
            wr_en    = 1'b1;
            wr_addr  = fl[AW-1:0];
            flen_in  = fl + 1'b1;
            fover_in = fo;
         end else begin
            flen_in  = fl;
            fover_in = 1'b1;
            fv       = 1'b0;
         end
         fvalid_in = fv;
         fstart_in = item.last_char;
         // A new filter arriving mid-topic spoils that topic's match.
         if (fstart_ff && !tstart_ff) begin
            status_in = ST_FAILED;
         end
      end else if (step) begin
         if (c == CH_PLUS || c == CH_HASH || c == CH_NUL) tv = 1'b0;
         if (tl < LW'(MAX_TOPIC_LEN)) begin
            tl = tl + 1'b1;
         end else begin
            tv = 1'b0;
         end

         case (status_ff)
            ST_SKIPPING: begin
               if (c == CH_SLASH) begin
                  if (p < flen_ff && rd_data0 == CH_SLASH) begin
                     st_n = ST_RUNNING;
                     p_n  = p + 1'b1;
                  end else begin
                     st_n = ST_FAILED;
                  end
               end
            end
            ST_RUNNING: begin
               if (p >= flen_ff) begin
                  st_n = ST_FAILED;
               end else if (rd_data0 == CH_HASH) begin
                  st_n = ST_HASH;
               end else if (rd_data0 == CH_PLUS) begin
                  p_n = p + 1'b1;
                  if (c == CH_SLASH) begin
                     if (p1 < {1'b0, flen_ff} && rd_data1 == CH_SLASH) begin
                        p_n = LW'(p1 + 1'b1);
                     end else begin
                        st_n = ST_FAILED;
                     end
                  end else begin
                     st_n = ST_SKIPPING;
                  end
               end else if (rd_data0 == c) begin
                  p_n = p + 1'b1;
               end else begin
                  st_n = ST_FAILED;
               end
            end
            default: begin
            end
         endcase

         // In a valid filter a '#' can only be the final byte, so the
         // trailing-'#' check needs the last filter byte and not a read.
         pn1 = {1'b0, p_n} + 1'b1;
         case (st_n)
            ST_HASH:   m = 1'b1;
            ST_FAILED: m = 1'b0;
            default:   m = (p_n == flen_ff) ||
                           (pn1 == {1'b0, flen_ff} && fprev_ff == CH_HASH);
         endcase

         if (item.last_char) begin
            result.matched   = m && fok && tv;
            result.filter_ok = fok;
            result.topic_ok  = tv;
            tlen_in   = '0;
            tvalid_in = 1'b1;
            status_in = ST_RUNNING;
            pos_in    = '0;
            tstart_in = 1'b1;
         end else begin
            tlen_in   = tl;
            tvalid_in = tv;
            status_in = st_n;
            pos_in    = p_n;
            tstart_in = 1'b0;
         end
      end
   end

   assign rd_pos = pos_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         flen_ff       <= '0;
         fover_ff      <= 1'b0;
         fvalid_ff     <= 1'b0;
         fprev_ff      <= 8'h00;
         plus_slash_ff <= 1'b0;
         fstart_ff     <= 1'b1;
         pos_ff        <= '0;
         tlen_ff       <= '0;
         tvalid_ff     <= 1'b1;
         status_ff     <= ST_RUNNING;
         tstart_ff     <= 1'b1;
      end else begin
         flen_ff       <= flen_in;
         fover_ff      <= fover_in;
         fvalid_ff     <= fvalid_in;
         fprev_ff      <= fprev_in;
         plus_slash_ff <= plus_slash_in;
         fstart_ff     <= fstart_in;
         pos_ff        <= pos_in;
         tlen_ff       <= tlen_in;
         tvalid_ff     <= tvalid_in;
         status_ff     <= status_in;
         tstart_ff     <= tstart_in;
      end
   end

endmodule

/* rtl/topic_filter_wildcard_match.sv */
// Top level of the topic filter wildcard matcher: request and response registers.
// Instantiates tfwm_match_core and tfwm_filter_store; uses tfwm_pkg.
//
// Usage: each request on the req_ channel carries one byte. With req_type low the
// byte belongs to a topic filter being loaded; req_last_char marks its final byte,
// after which the filter is complete and its validity flag is settled. With req_type
// high the byte belongs to a topic, which is checked and matched on the fly against
// the stored filter. Only the final byte of a topic produces a response on the rsp_
// channel: rsp_matched, rsp_filter_ok and rsp_topic_ok. All other requests produce
// no response.
// rsp_valid is registered: the final topic byte sits in the request register, and its
// result is then captured in the response register. Throughput: one request per cycle,
// sustained for filter and topic bytes alike while no pending response stalls a final
// topic byte. The rate is set by the match position update, which reads the filter bytes
// at the current position and the one after it from registered memory ports each cycle.
// Reset clears all control state: no filter is loaded, so filter_ok reads 0 until a
// filter has been loaded in full. The filter memory needs no clearing pass.
// When the receiver stalls, the pending response holds in its register; requests
// that produce no response keep flowing, and a request that would produce a second
// response waits in the request register, which drops req_ready.
module topic_filter_wildcard_match #(
   parameter int MAX_TOPIC_LEN = 128
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_type,
   input  logic [7:0] req_char_byte,
   input  logic       req_last_char,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_matched,
   output logic       rsp_filter_ok,
   output logic       rsp_topic_ok
);
   import tfwm_pkg::*;

   localparam int AW = $clog2(MAX_TOPIC_LEN);
   localparam int LW = $clog2(MAX_TOPIC_LEN + 1);

   logic       in_valid_ff, in_valid_in;
   item_type   in_item_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_result_ff;

   logic          emit;
   logic          advance;
   result_type    result;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic [LW-1:0] rd_pos;
   logic [7:0]    rd_data0;
   logic [7:0]    rd_data1;

   // Only the final byte of a topic needs the response register; everything
   // else moves on whether or not the receiver is ready.
   assign emit    = in_item_ff.is_topic && in_item_ff.last_char;
   assign advance = in_valid_ff && (!emit || !rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff.is_topic  <= req_type;
         in_item_ff.char_byte <= req_char_byte;
         in_item_ff.last_char <= req_last_char;
      end
      if (advance && emit) begin
         rsp_result_ff <= result;
      end
   end

   tfwm_match_core #(
      .MAX_TOPIC_LEN(MAX_TOPIC_LEN)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .item     (in_item_ff),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_pos   (rd_pos),
      .result   (result)
   );

   tfwm_filter_store #(
      .MAX_TOPIC_LEN(MAX_TOPIC_LEN)
   ) u_store (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_pos   (rd_pos),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_matched   = rsp_result_ff.matched;
   assign rsp_filter_ok = rsp_result_ff.filter_ok;
   assign rsp_topic_ok  = rsp_result_ff.topic_ok;

endmodule
